/* rtl/sha1md_pkg.sv */
// ----------------------------------------------------------------------------
// sha1md_pkg
// Shared types and constants of the SHA-1 message digest engine: controller
// states, datapath commands, status and the standard SHA-1 constants.
// ----------------------------------------------------------------------------
package sha1md_pkg;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD80,
    S_ZERO,
    S_LEN,
    S_COMP,
    S_FOLD,
    S_EMIT
  } state_t;

  // Source of the byte shifted into the block register
  typedef enum logic [1:0] {
    SEL_MSG,
    SEL_PAD80,
    SEL_ZERO,
    SEL_LEN
  } byte_sel_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic       shift;
    byte_sel_t  sel;
    logic       load_vars;
    logic       round_en;
    logic [6:0] round;
    logic       fold;
    logic       reinit;
    logic [2:0] word_idx;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [5:0] pos;
  } status_t;

  // Byte positions inside a 64-byte block
  localparam logic [5:0] POS_LAST = 6'd63;
  localparam logic [5:0] POS_LEN  = 6'd56;

  // Round and word counts
  localparam logic [6:0] ROUND_LAST = 7'd79;
  localparam logic [6:0] ROUND_G1   = 7'd20;
  localparam logic [6:0] ROUND_G2   = 7'd40;
  localparam logic [6:0] ROUND_G3   = 7'd60;
  localparam logic [2:0] WORD_LAST  = 3'd4;

  // Initial chaining values
  localparam logic [31:0] H_INIT [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  // Round constants
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

endpackage

/* rtl/sha1md_ctrl.sv */
// ----------------------------------------------------------------------------
// sha1md_ctrl
// Sequencer of the digest engine: takes input items, runs padding, the 80
// compression rounds, the chaining fold and the five-word digest output.
// ----------------------------------------------------------------------------
module sha1md_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               has_byte,
  input  logic               end_of_message,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         word_number,
  output logic               last_word,
  input  sha1md_pkg::status_t st,
  output sha1md_pkg::cmd_t    cmd
);

  sha1md_pkg::state_t state, state_next;
  sha1md_pkg::state_t ret, ret_next;
  logic [6:0] rnd, rnd_next;
  logic [2:0] idx, idx_next;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha1md_pkg::S_IDLE;
      ret   <= sha1md_pkg::S_IDLE;
      rnd   <= '0;
      idx   <= '0;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      rnd   <= rnd_next;
      idx   <= idx_next;
    end
  end

  assign word_number = idx;
  assign last_word   = (idx == sha1md_pkg::WORD_LAST);

  // Next state and commands
  always_comb begin
    state_next   = state;
    ret_next     = ret;
    rnd_next     = rnd;
    idx_next     = idx;
    in_stall     = 1'b1;
    out_valid    = 1'b0;
    cmd          = '0;
    cmd.sel      = sha1md_pkg::SEL_MSG;
    cmd.round    = rnd;
    cmd.word_idx = idx;

    case (state)
      sha1md_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.shift = has_byte;
          if (has_byte && st.pos == sha1md_pkg::POS_LAST) begin
            // block filled: compress, then pad if the message ends here
            state_next    = sha1md_pkg::S_COMP;
            ret_next      = end_of_message ? sha1md_pkg::S_PAD80 : sha1md_pkg::S_IDLE;
            cmd.load_vars = 1'b1;
            rnd_next      = '0;
          end else if (end_of_message) begin
            state_next = sha1md_pkg::S_PAD80;
          end
        end
      end

      sha1md_pkg::S_PAD80: begin
        cmd.shift = 1'b1;
        cmd.sel   = sha1md_pkg::SEL_PAD80;
        if (st.pos == sha1md_pkg::POS_LAST) begin
          state_next    = sha1md_pkg::S_COMP;
          ret_next      = sha1md_pkg::S_ZERO;
          cmd.load_vars = 1'b1;
          rnd_next      = '0;
        end else begin
          state_next = sha1md_pkg::S_ZERO;
        end
      end

      sha1md_pkg::S_ZERO: begin
        // zero fill up to the length field
        if (st.pos == sha1md_pkg::POS_LEN) begin
          state_next = sha1md_pkg::S_LEN;
        end else begin
          cmd.shift = 1'b1;
          cmd.sel   = sha1md_pkg::SEL_ZERO;
          if (st.pos == sha1md_pkg::POS_LAST) begin
            state_next    = sha1md_pkg::S_COMP;
            ret_next      = sha1md_pkg::S_ZERO;
            cmd.load_vars = 1'b1;
            rnd_next      = '0;
          end
        end
      end

      sha1md_pkg::S_LEN: begin
        cmd.shift = 1'b1;
        cmd.sel   = sha1md_pkg::SEL_LEN;
        if (st.pos == sha1md_pkg::POS_LAST) begin
          state_next    = sha1md_pkg::S_COMP;
          ret_next      = sha1md_pkg::S_EMIT;
          cmd.load_vars = 1'b1;
          rnd_next      = '0;
        end
      end

      sha1md_pkg::S_COMP: begin
        cmd.round_en = 1'b1;
        rnd_next     = rnd + 7'd1;
        if (rnd == sha1md_pkg::ROUND_LAST) begin
          state_next = sha1md_pkg::S_FOLD;
        end
      end

      sha1md_pkg::S_FOLD: begin
        cmd.fold   = 1'b1;
        state_next = ret;
        if (ret == sha1md_pkg::S_EMIT) begin
          idx_next = '0;
        end
      end

      sha1md_pkg::S_EMIT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (idx == sha1md_pkg::WORD_LAST) begin
            cmd.reinit = 1'b1;
            state_next = sha1md_pkg::S_IDLE;
          end else begin
            idx_next = idx + 3'd1;
          end
        end
      end

      default: begin
        state_next = sha1md_pkg::S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/sha1md_datapath.sv */
// ----------------------------------------------------------------------------
// sha1md_datapath
// Block register (doubles as the rolling message schedule), bit counter,
// working variables, one SHA-1 round per cycle and the chaining values.
// ----------------------------------------------------------------------------
module sha1md_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          data_byte,
  input  sha1md_pkg::cmd_t    cmd,
  output sha1md_pkg::status_t st,
  output logic [31:0]         digest_word
);

  logic [511:0] blk;
  logic [63:0]  bit_count;
  logic [5:0]   pos;
  logic [31:0]  chain [5];
  logic [31:0]  va, vb, vc, vd, ve;

  logic [7:0]   byte_in;
  logic [31:0]  w0, w2, w8, w13, wx, wnew;
  logic [31:0]  f, k, tmp;

  assign st.pos = pos;

  // Byte entering the block
  always_comb begin
    case (cmd.sel)
      sha1md_pkg::SEL_MSG:   byte_in = data_byte;
      sha1md_pkg::SEL_PAD80: byte_in = 8'h80;
      sha1md_pkg::SEL_ZERO:  byte_in = 8'h00;
      sha1md_pkg::SEL_LEN:   byte_in = bit_count[63:56];
      default:               byte_in = 8'h00;
    endcase
  end

  // Schedule taps: word i sits at blk[511-32i -: 32]
  assign w0   = blk[511:480];
  assign w2   = blk[447:416];
  assign w8   = blk[255:224];
  assign w13  = blk[95:64];
  assign wx   = w13 ^ w8 ^ w2 ^ w0;
  assign wnew = {wx[30:0], wx[31]};

  // Round function and constant
  always_comb begin
    if (cmd.round < sha1md_pkg::ROUND_G1) begin
      f = (vb & vc) | (~vb & vd);
      k = sha1md_pkg::K0;
    end else if (cmd.round < sha1md_pkg::ROUND_G2) begin
      f = vb ^ vc ^ vd;
      k = sha1md_pkg::K1;
    end else if (cmd.round < sha1md_pkg::ROUND_G3) begin
      f = (vb & vc) | (vb & vd) | (vc & vd);
      k = sha1md_pkg::K2;
    end else begin
      f = vb ^ vc ^ vd;
      k = sha1md_pkg::K3;
    end
  end

  assign tmp = {va[26:0], va[31:27]} + f + ve + k + w0;

  // Block register: byte shift on load, word rotate with expansion per round
  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      blk <= {blk[503:0], byte_in};
    end else if (cmd.round_en) begin
      blk <= {blk[479:0], wnew};
    end
  end

  // Byte position and message bit count
  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      bit_count <= '0;
    end else begin
      if (cmd.shift) begin
        pos <= pos + 6'd1;
      end
      if (cmd.shift && cmd.sel == sha1md_pkg::SEL_MSG) begin
        bit_count <= bit_count + 64'd8;
      end else if (cmd.shift && cmd.sel == sha1md_pkg::SEL_LEN) begin
        // length leaves MSB first; eight bytes leave the counter at zero
        bit_count <= {bit_count[55:0], 8'h00};
      end
    end
  end

  // Working variables
  always_ff @(posedge clk) begin
    if (cmd.load_vars) begin
      va <= chain[0];
      vb <= chain[1];
      vc <= chain[2];
      vd <= chain[3];
      ve <= chain[4];
    end else if (cmd.round_en) begin
      va <= tmp;
      vb <= va;
      vc <= {vb[1:0], vb[31:2]};
      vd <= vc;
      ve <= vd;
    end
  end

  // Chaining values
  always_ff @(posedge clk) begin
    if (rst || cmd.reinit) begin
      for (int i = 0; i < 5; i++) begin
        chain[i] <= sha1md_pkg::H_INIT[i];
      end
    end else if (cmd.fold) begin
      chain[0] <= chain[0] + va;
      chain[1] <= chain[1] + vb;
      chain[2] <= chain[2] + vc;
      chain[3] <= chain[3] + vd;
      chain[4] <= chain[4] + ve;
    end
  end

  // Digest word select
  always_comb begin
    case (cmd.word_idx)
      3'd0:    digest_word = chain[0];
      3'd1:    digest_word = chain[1];
      3'd2:    digest_word = chain[2];
      3'd3:    digest_word = chain[3];
      default: digest_word = chain[4];
    endcase
  end

endmodule

/* rtl/sha1_message_digest_top.sv */
// Input: a byte item is taken only while the controller is idle; a byte that fills a 64-byte
//   block starts its compression (80 rounds of one shared round unit, then the chaining fold).
// End of message: padding and one or two block compressions, then five digest words,
//   one per cycle when not stalled. One item at a time.
// Reset (rst, synchronous): chaining values to the SHA-1 initial values,
//   byte position and bit count to zero, controller idle. No clearing pass.
// ----------------------------------------------------------------------------
// sha1_message_digest_top
// SHA-1 engine taking one message byte per item and returning the 160-bit
// digest as five 32-bit words at the end of each message.
// ----------------------------------------------------------------------------
module sha1_message_digest_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_number,
  output logic        last_word
);

  sha1md_pkg::cmd_t    cmd;
  sha1md_pkg::status_t st;

  // Controller
  sha1md_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .has_byte       (has_byte),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .word_number    (word_number),
    .last_word      (last_word),
    .st             (st),
    .cmd            (cmd)
  );

  // Datapath
  sha1md_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .data_byte   (data_byte),
    .cmd         (cmd),
    .st          (st),
    .digest_word (digest_word)
  );

endmodule

/* sim/sha1_message_digest_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sha1_message_digest_checker
// Watches both channels of the SHA-1 engine. It keeps its own SHA-1 state and
// works out the five digest words of each message, then compares every digest
// item that leaves the block against the oldest outstanding word.
// ----------------------------------------------------------------------------
module sha1_message_digest_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        end_of_message,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] digest_word,
  input  logic [2:0]  word_number,
  input  logic        last_word,
  output int          failures,
  output int          pending_words,
  output int          words_checked
);

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  num;
    logic        last;
  } digest_item_t;

  // Predicted engine state
  logic [31:0]  chain_h [5];
  logic [31:0]  msg_block [16];
  logic [63:0]  bit_count;
  digest_item_t digest_fifo [$];

  function automatic logic [31:0] rotl(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void put_byte(int pos, logic [7:0] v);
    msg_block[pos / 4][(3 - (pos % 4)) * 8 +: 8] = v;
  endfunction

  // One 80-round compression of msg_block into the chaining value
  function automatic void compress_block();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, wt, sum;
    int t;
    for (t = 0; t < 16; t++) w[t] = msg_block[t];
    a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3]; e = chain_h[4];
    for (t = 0; t < 80; t++) begin
      if (t < 16) begin
        wt = w[t];
      end else begin
        wt = rotl(w[(t - 3) & 15] ^ w[(t - 8) & 15] ^ w[(t - 14) & 15] ^ w[t & 15], 1);
        w[t & 15] = wt;
      end
      if (t < sha1md_pkg::ROUND_G1) begin
        f = (b & c) | (~b & d);
        k = sha1md_pkg::K0;
      end else if (t < sha1md_pkg::ROUND_G2) begin
        f = b ^ c ^ d;
        k = sha1md_pkg::K1;
      end else if (t < sha1md_pkg::ROUND_G3) begin
        f = (b & c) | (b & d) | (c & d);
        k = sha1md_pkg::K2;
      end else begin
        f = b ^ c ^ d;
        k = sha1md_pkg::K3;
      end
      sum = rotl(a, 5) + f + e + k + wt;
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = sum;
    end
    chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d; chain_h[4] += e;
  endfunction

  // Padding, length field, final compression(s) and the five digest words
  function automatic void finish_message();
    int off, i;
    digest_item_t item;
    off = int'(bit_count[8:3]);
    put_byte(off, 8'h80);
    for (i = off + 1; i < 64; i++) put_byte(i, 8'h00);
    if (off >= sha1md_pkg::POS_LEN) begin
      compress_block();
      for (i = 0; i < 16; i++) msg_block[i] = '0;
    end
    msg_block[14] = bit_count[63:32];
    msg_block[15] = bit_count[31:0];
    compress_block();
    for (i = 0; i < 5; i++) begin
      item.word = chain_h[i];
      item.num  = 3'(i);
      item.last = (3'(i) == sha1md_pkg::WORD_LAST);
      digest_fifo = {digest_fifo, item};
    end
    for (i = 0; i < 5; i++) chain_h[i] = sha1md_pkg::H_INIT[i];
    bit_count = '0;
  endfunction

  // Follow accepted input items
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 5; i++) chain_h[i] = sha1md_pkg::H_INIT[i];
      for (int i = 0; i < 16; i++) msg_block[i] = '0;
      bit_count = '0;
      digest_fifo.delete();
    end else if (in_valid && !in_stall) begin
      if (has_byte) begin
        put_byte(int'(bit_count[8:3]), data_byte);
        bit_count += 64'd8;
        if (bit_count[8:3] == 6'd0) compress_block();
      end
      if (end_of_message) finish_message();
    end
    pending_words = digest_fifo.size();
  end

  // Compare each digest item with the oldest prediction
  always @(posedge clk) begin
    digest_item_t exp_item;
    if (!rst && out_valid && !out_stall) begin
      if (digest_fifo.size() == 0) begin
        failures++;
        $display("%0t: digest item with nothing expected: word %h num %0d last %b",
                 $time, digest_word, word_number, last_word);
      end else begin
        exp_item = digest_fifo.pop_front();
        words_checked++;
        if (digest_word !== exp_item.word) begin
          failures++;
          $display("%0t: digest_word expected %h actual %h",
                   $time, exp_item.word, digest_word);
        end
        if (word_number !== exp_item.num) begin
          failures++;
          $display("%0t: word_number expected %0d actual %0d",
                   $time, exp_item.num, word_number);
        end
        if (last_word !== exp_item.last) begin
          failures++;
          $display("%0t: last_word expected %b actual %b",
                   $time, exp_item.last, last_word);
        end
      end
    end
  end

endmodule

/* sim/sha1_message_digest_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sha1_message_digest_top_tb
// Feeds messages to the SHA-1 engine byte by byte: a few fixed messages, then
// messages sized around the block and padding boundaries, then short random
// ones, with random gaps and output stalls. A checker module beside the block
// predicts and compares every digest word.
// ----------------------------------------------------------------------------
module sha1_message_digest_top_tb;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        has_byte;
  logic        end_of_message;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] digest_word;
  logic [2:0]  word_number;
  logic        last_word;

  int   fail_count;
  int   pending_words;
  int   words_checked;
  int   items_sent;
  int   messages_sent;
  logic steady;

  sha1_message_digest_top i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .has_byte       (has_byte),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .digest_word    (digest_word),
    .word_number    (word_number),
    .last_word      (last_word)
  );

  sha1_message_digest_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .has_byte       (has_byte),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .digest_word    (digest_word),
    .word_number    (word_number),
    .last_word      (last_word),
    .failures       (fail_count),
    .pending_words  (pending_words),
    .words_checked  (words_checked)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Random output stalls, none during the steady stretch
  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(0, 99) < 26);
  end

  // One item: random gap first, then hold until taken
  task automatic send_item(input logic [7:0] b, input logic hb, input logic eom);
    while (!steady && $urandom_range(0, 99) < 26) begin
      in_valid       <= 1'b0;
      data_byte      <= 8'($urandom);
      has_byte       <= 1'($urandom);
      end_of_message <= 1'($urandom);
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    data_byte      <= b;
    has_byte       <= hb;
    end_of_message <= eom;
    if (hb || eom) items_sent++;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
  endtask

  // Message of random bytes; the end rides on the last byte or comes alone
  task automatic send_message(input int len);
    logic end_apart;
    int   i;
    end_apart = (len == 0) || $urandom_range(0, 1);
    for (i = 0; i < len; i++) begin
      // stray items that carry neither flag
      if ($urandom_range(0, 99) < 5) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, !end_apart && (i == len - 1));
    end
    if (end_apart) send_item(8'($urandom), 1'b0, 1'b1);
    messages_sent++;
  endtask

  // Stimulus and verdict
  initial begin
    int boundary_len [4] = '{55, 56, 63, 64};
    int m;
    items_sent     = 0;
    messages_sent  = 0;
    steady         <= 1'b0;
    rst            <= 1'b1;
    in_valid       <= 1'b0;
    data_byte      <= 8'h00;
    has_byte       <= 1'b0;
    end_of_message <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // empty message
    send_item(8'hFF, 1'b0, 1'b1);
    messages_sent++;
    // "abc", end on the last byte
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    messages_sent++;
    // neither flag: ignored
    send_item(8'hFF, 1'b0, 1'b0);
    // byte extremes, end alone
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h55, 1'b1, 1'b0);
    send_item(8'hAA, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    messages_sent++;
    // one byte with end together
    send_item(8'hFF, 1'b1, 1'b1);
    messages_sent++;

    // lengths at the padding and block boundaries
    for (m = 0; m < 4; m++) begin
      steady <= (m == 2);
      send_message(boundary_len[m]);
    end
    steady <= 1'b0;

    // short random messages
    while (items_sent < 330) send_message($urandom_range(0, 24));

    in_valid       <= 1'b0;
    has_byte       <= 1'b0;
    end_of_message <= 1'b0;
    do @(negedge clk); while (pending_words != 0);
    repeat (20) @(posedge clk);

    $display("Covered %0d items in %0d messages; %0d digest words compared.",
             items_sent, messages_sent, words_checked);
    if (fail_count == 0) begin
      $display("sha1_message_digest_top_tb OK");
    end else begin
      $display("sha1_message_digest_top_tb NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("Timeout with %0d digest words outstanding.", pending_words);
    $display("sha1_message_digest_top_tb NOT OK");
    $finish;
  end

endmodule

/* filelist.f */
rtl/sha1md_pkg.sv
rtl/sha1md_ctrl.sv
rtl/sha1md_datapath.sv
rtl/sha1_message_digest_top.sv
sim/sha1_message_digest_checker.sv
sim/sha1_message_digest_top_tb.sv
